// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Immediate-condition property, checked at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== hw/rtl/ftanh_pkg.sv =====
// Types, constants and binary16 arithmetic helpers for the tanh pipeline.
package ftanh_pkg;

    localparam logic [15:0] H_A7    = 16'h0001;
    localparam logic [15:0] H_A5    = 16'h00F9;
    localparam logic [15:0] H_A3    = 16'h1138;
    localparam logic [15:0] H_A1    = 16'h1D03;
    localparam logic [15:0] H_B6    = 16'h0010;
    localparam logic [15:0] H_B4    = 16'h07C5;
    localparam logic [15:0] H_B2    = 16'h18A5;
    localparam logic [15:0] H_B0    = 16'h1D03;
    localparam logic [15:0] H_UPPER = 16'h4308;
    localparam logic [15:0] H_LOWER = 16'hC308;
    localparam logic [15:0] H_QUIET = 16'h0200;

    localparam int NST = 23;    // pipeline stages, output register included
    localparam int QW  = 14;    // quotient bits kept by the divider
    localparam int MW  = 49;    // width of an unrounded magnitude

    typedef struct packed {
        logic [10:0]       m;
        logic signed [9:0] e;
    } t_unp;

    typedef struct packed {
        logic [MW-1:0]     m;
        logic signed [9:0] e;
    } t_mexp;

    typedef struct packed {
        logic [15:0]       x;
        logic [15:0]       x2;
        logic [15:0]       p;
        logic [15:0]       q;
        logic [15:0]       y;
        logic              nan;
        logic              last;
        t_mexp             pm;
        t_mexp             qm;
        logic [11:0]       rem;
        logic [QW-1:0]     quo;
        logic [10:0]       mb;
        logic signed [9:0] de;
        logic              sgn;
        logic              zro;
    } t_stage;

    function automatic t_unp unpack(logic [15:0] h);
        t_unp u;
        if (h[14:10] == 5'd0) begin
            u.m = {1'b0, h[9:0]};
            u.e = -10'sd24;
        end else begin
            u.m = {1'b1, h[9:0]};
            u.e = $signed({5'd0, h[14:10]}) - 10'sd25;
        end
        return u;
    endfunction

    // exact product of two finite binary16 magnitudes
    function automatic t_mexp mul_ex(logic [15:0] a, logic [15:0] b);
        t_unp  ua;
        t_unp  ub;
        t_mexp r;
        ua = unpack(a);
        ub = unpack(b);
        r.m = {27'd0, ({11'd0, ua.m} * {11'd0, ub.m})};
        r.e = ua.e + ub.e;
        return r;
    endfunction

    // align addend a against a product, far bits fold into a sticky bit
    function automatic t_mexp fma_align(logic [15:0] a, t_mexp pr);
        t_unp        ua;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] m;
        int          ehi;
        int          elo;
        int          d;
        t_mexp       r;
        ua = unpack(a);
        if (pr.m == '0) begin
            hi = {53'd0, ua.m}; ehi = int'(ua.e); lo = '0; elo = ehi;
        end else if (ua.m == '0) begin
            hi = {15'd0, pr.m}; ehi = int'(pr.e); lo = '0; elo = ehi;
        end else if (ua.e >= pr.e) begin
            hi = {53'd0, ua.m}; ehi = int'(ua.e); lo = {15'd0, pr.m}; elo = int'(pr.e);
        end else begin
            hi = {15'd0, pr.m}; ehi = int'(pr.e); lo = {53'd0, ua.m}; elo = int'(ua.e);
        end
        d = ehi - elo;
        m = hi << 26;
        if (d <= 26) begin
            m = m + (lo << (26 - d));
        end else begin
            m = (m + (lo >> (d - 26))) |
                {63'd0, ((lo & ((64'd1 << (d - 26)) - 64'd1)) != 64'd0)};
        end
        r.m = m[MW-1:0];
        r.e = 10'(ehi - 26);
        return r;
    endfunction

    // round s * m * 2^e to binary16, nearest even, subnormals kept
    function automatic logic [15:0] round16(logic s, t_mexp v);
        int          bl;
        int          sh;
        int          e2;
        int          be;
        logic [63:0] mm;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] q;
        bl = 0;
        for (int i = 0; i < MW; i++) begin
            if (v.m[i]) bl = i + 1;
        end
        if (v.m == '0) return {s, 15'd0};
        sh = bl - 11;
        if (int'(v.e) + sh < -24) sh = -24 - int'(v.e);
        mm = {{(64-MW){1'b0}}, v.m};
        if (sh <= 0) begin
            q = mm << (-sh);
        end else begin
            rem  = mm & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q    = mm >> sh;
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        end
        if (q >= 64'd2048) begin
            q  = q >> 1;
            sh = sh + 1;
        end
        e2 = int'(v.e) + sh;
        if (q >= 64'd1024) begin
            be = e2 + 25;
            if (be >= 31) return {s, 15'h7C00};
            return {s, be[4:0], q[9:0]};
        end
        return {s, 5'd0, q[9:0]};
    endfunction

endpackage

// ===== hw/rtl/fp16_tanh_rational_top.sv =====
// Pipelined binary16 tanh by a rational approximation.
// One beat per cycle is sustained while the output is not stalled.
// The whole pipeline advances together whenever the output register is empty or drained,
// so a stall at the output holds every stage and loses nothing.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only; data is unreset.
`include "assert_macros.svh"
module fp16_tanh_rational_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_x_bits,
    input  logic        i_last_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_y_bits,
    output logic        o_last_out
);
    import ftanh_pkg::*;

    // Stage map:
    //   0      clamp, NaN detect
    //   1-2    x squared (product, round)
    //   3-11   three fused steps per chain: product, align and add, round
    //   12-13  numerator times x
    //   14     normalise divider operands
    //   15-21  restoring divide, two quotient bits a stage
    //   22     final rounding, NaN and zero select (output register)

    t_stage           r_st [NST];
    t_stage           n_st [NST];
    logic [NST-1:0]   r_vld;
    logic             w_adv;

    // advance when the output register is empty or being taken
    assign w_adv       = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[NST-1];
    assign o_y_bits    = r_st[NST-1].y;
    assign o_last_out  = r_st[NST-1].last;

    always_comb begin
        t_unp        ua;
        t_unp        ub;
        logic [10:0] na;
        logic [10:0] nb;
        logic signed [9:0] ea;
        logic signed [9:0] eb;
        logic [11:0] r;
        logic        bit_q;
        ua    = '0;
        ub    = '0;
        na    = '0;
        nb    = '0;
        ea    = '0;
        eb    = '0;
        r     = '0;
        bit_q = 1'b0;
        // stage 0: clamp the input to the bound of its sign
        n_st[0]      = r_st[0];
        n_st[0].x    = i_x_bits;
        n_st[0].last = i_last_in;
        n_st[0].nan  = (i_x_bits[14:10] == 5'h1F) && (i_x_bits[9:0] != 10'd0);
        n_st[0].y    = i_x_bits | H_QUIET;
        if (!i_x_bits[15]) begin
            if (i_x_bits > H_UPPER) n_st[0].x = H_UPPER;
        end else begin
            if (i_x_bits > H_LOWER) n_st[0].x = H_LOWER;
        end
        for (int k = 1; k < NST; k++) begin
            n_st[k] = r_st[k-1];
            case (k)
                1: n_st[k].pm = mul_ex(r_st[k-1].x, r_st[k-1].x);
                2: begin
                    n_st[k].x2 = round16(1'b0, r_st[k-1].pm);
                    n_st[k].p  = H_A7;
                    n_st[k].q  = H_B6;
                end
                3, 6, 9: begin
                    n_st[k].pm = mul_ex(r_st[k-1].p, r_st[k-1].x2);
                    n_st[k].qm = mul_ex(r_st[k-1].q, r_st[k-1].x2);
                end
                4: begin
                    n_st[k].pm = fma_align(H_A5, r_st[k-1].pm);
                    n_st[k].qm = fma_align(H_B4, r_st[k-1].qm);
                end
                7: begin
                    n_st[k].pm = fma_align(H_A3, r_st[k-1].pm);
                    n_st[k].qm = fma_align(H_B2, r_st[k-1].qm);
                end
                10: begin
                    n_st[k].pm = fma_align(H_A1, r_st[k-1].pm);
                    n_st[k].qm = fma_align(H_B0, r_st[k-1].qm);
                end
                5, 8, 11: begin
                    n_st[k].p = round16(1'b0, r_st[k-1].pm);
                    n_st[k].q = round16(1'b0, r_st[k-1].qm);
                end
                12: begin
                    n_st[k].pm  = mul_ex(r_st[k-1].p, r_st[k-1].x);
                    n_st[k].sgn = r_st[k-1].p[15] ^ r_st[k-1].x[15];
                end
                13: n_st[k].p = round16(r_st[k-1].sgn, r_st[k-1].pm);
                14: begin
                    // bring both mantissas to a leading one
                    ua = unpack(r_st[k-1].p);
                    ub = unpack(r_st[k-1].q);
                    na = ua.m; ea = ua.e;
                    nb = ub.m; eb = ub.e;
                    for (int i = 0; i < 10; i++) begin
                        if (!na[10] && na != 11'd0) begin
                            na = na << 1; ea = ea - 10'sd1;
                        end
                        if (!nb[10] && nb != 11'd0) begin
                            nb = nb << 1; eb = eb - 10'sd1;
                        end
                    end
                    n_st[k].zro = (ua.m == 11'd0);
                    n_st[k].sgn = r_st[k-1].p[15] ^ r_st[k-1].q[15];
                    n_st[k].rem = {1'b0, na};
                    n_st[k].mb  = nb;
                    n_st[k].quo = '0;
                    n_st[k].de  = ea - eb - 10'(QW);
                end
                15, 16, 17, 18, 19, 20, 21: begin
                    r = r_st[k-1].rem;
                    for (int j = 0; j < 2; j++) begin
                        bit_q = (r >= {1'b0, r_st[k-1].mb});
                        if (bit_q) r = r - {1'b0, r_st[k-1].mb};
                        n_st[k].quo = {n_st[k].quo[QW-2:0], bit_q};
                        r = r << 1;
                    end
                    n_st[k].rem = r;
                end
                22: begin
                    if (!r_st[k-1].nan) begin
                        if (r_st[k-1].zro) begin
                            n_st[k].y = {r_st[k-1].sgn, 15'd0};
                        end else begin
                            n_st[k].y = round16(r_st[k-1].sgn,
                                {{(MW-QW-1){1'b0}}, r_st[k-1].quo,
                                 (r_st[k-1].rem != 12'd0), r_st[k-1].de});
                        end
                    end
                end
                default: n_st[k] = r_st[k-1];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // payload stages carry no reset; hold on stall
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NST; k++) r_st[k] <= n_st[k];
        end
    end

    `ASSERT_NEXT(a_stall_holds_vld, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(r_vld))
    `ASSERT_AT(a_nan_out_quiet, i_clk, i_rst_n,
        !(o_out_valid && r_st[NST-1].nan) || (o_y_bits[14:10] == 5'h1F && o_y_bits[9]))
    `ASSERT_AT(a_num_out_finite, i_clk, i_rst_n,
        !(o_out_valid && !r_st[NST-1].nan) || (o_y_bits[14:10] != 5'h1F))

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the binary16 rational tanh pipeline.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ftanh_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_x_bits = '0;
    logic        i_last_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_y_bits;
    logic        o_last_out;

    fp16_tanh_rational_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x_bits    (i_x_bits),
        .i_last_in   (i_last_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_y_bits    (o_y_bits),
        .o_last_out  (o_last_out)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Binary16 arithmetic, exact then one rounding per operation
    // ---------------------------------------------------------------

    // Split a finite half into magnitude and exponent: value = m * 2^e.
    function automatic void half_split(input logic [15:0] h, output logic [63:0] m,
                                       output int e);
        if (h[14:10] == 5'd0) begin
            m = {54'd0, h[9:0]};
            e = -24;
        end else begin
            m = {53'd0, 1'b1, h[9:0]};
            e = int'(h[14:10]) - 25;
        end
    endfunction

    // Round s * mag * 2^ex to nearest even; subnormals survive, overflow saturates to inf.
    function automatic logic [15:0] half_round(input logic s, input logic [63:0] mag,
                                               input int ex);
        int          nbits;
        int          sh;
        int          eo;
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] halfway;
        nbits = 0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) nbits = i + 1;
        end
        if (mag == 64'd0) return {s, 15'd0};
        sh = nbits - 11;
        if (ex + sh < -24) sh = -24 - ex;
        if (sh <= 0) begin
            r = mag << (-sh);
        end else if (sh < 64) begin
            rem     = mag & ((64'd1 << sh) - 64'd1);
            halfway = 64'd1 << (sh - 1);
            r       = mag >> sh;
            if (rem > halfway || (rem == halfway && r[0])) r = r + 64'd1;
        end else if (sh == 64) begin
            r = (mag > (64'd1 << 63)) ? 64'd1 : 64'd0;
        end else begin
            r = 64'd0;
        end
        if (r >= 64'd2048) begin
            r  = r >> 1;
            sh = sh + 1;
        end
        eo = ex + sh;
        if (r >= 64'd1024) begin
            if (eo + 25 >= 31) return {s, 15'h7C00};
            return {s, 5'(eo + 25), r[9:0]};
        end
        return {s, 5'd0, r[9:0]};
    endfunction

    function automatic logic [15:0] half_mul(input logic [15:0] a, input logic [15:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        half_split(a, ma, ea);
        half_split(b, mb, eb);
        return half_round(a[15] ^ b[15], ma * mb, ea + eb);
    endfunction

    // acc + b*c for non-negative finite operands, single rounding.
    function automatic logic [15:0] half_fma(input logic [15:0] acc, input logic [15:0] b,
                                             input logic [15:0] c);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mc;
        logic [63:0] prod;
        logic [63:0] big;
        logic [63:0] tiny;
        int          ea;
        int          eb;
        int          ec;
        int          ep;
        int          ebig;
        int          etiny;
        half_split(acc, ma, ea);
        half_split(b, mb, eb);
        half_split(c, mc, ec);
        prod = mb * mc;
        ep   = eb + ec;
        if (prod == 64'd0) return half_round(1'b0, ma, ea);
        if (ma == 64'd0) return half_round(1'b0, prod, ep);
        if (ea >= ep) begin
            big = ma; ebig = ea; tiny = prod; etiny = ep;
        end else begin
            big = prod; ebig = ep; tiny = ma; etiny = ea;
        end
        if (ebig - etiny <= 40) return half_round(1'b0, (big << (ebig - etiny)) + tiny, etiny);
        // far-off term only nudges the sticky position
        return half_round(1'b0, (big << 20) | 64'd1, ebig - 20);
    endfunction

    function automatic logic [15:0] half_div(input logic [15:0] a, input logic [15:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] quo;
        logic [63:0] rem;
        int          ea;
        int          eb;
        half_split(a, ma, ea);
        half_split(b, mb, eb);
        if (ma == 64'd0 || mb == 64'd0) return {a[15] ^ b[15], 15'd0};
        while (ma < 64'd1024) begin ma = ma << 1; ea--; end
        while (mb < 64'd1024) begin mb = mb << 1; eb--; end
        quo = (ma << 30) / mb;
        rem = (ma << 30) % mb;
        return half_round(a[15] ^ b[15], (quo << 1) | {63'd0, rem != 64'd0}, ea - eb - 31);
    endfunction

    function automatic logic [15:0] tanh_half(input logic [15:0] x);
        logic [15:0] xc;
        logic [15:0] sq;
        logic [15:0] num;
        logic [15:0] den;
        if (x[14:10] == 5'h1F && x[9:0] != 10'd0) return x | H_QUIET;
        xc = x;
        if (!x[15] && x > H_UPPER) xc = H_UPPER;
        if (x[15] && x > H_LOWER) xc = H_LOWER;
        sq  = half_mul(xc, xc);
        num = half_fma(H_A5, H_A7, sq);
        num = half_fma(H_A3, num, sq);
        num = half_fma(H_A1, num, sq);
        num = half_mul(num, xc);
        den = half_fma(H_B4, H_B6, sq);
        den = half_fma(H_B2, den, sq);
        den = half_fma(H_B0, den, sq);
        return half_div(num, den);
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: expected tanh beats in acceptance order
    // ---------------------------------------------------------------
    class tanh_scoreboard;
        logic [16:0] expected_q[$];   // {last, y}
        int          errors;
        int          matched;

        function void note_input(logic [15:0] x, logic last);
            expected_q.push_back({last, tanh_half(x)});
        endfunction

        function void check_result(logic [15:0] y, logic last);
            logic [16:0] want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat y=%h last=%b", $realtime, y, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (want[15:0] !== y) begin
                $display("%0t: y mismatch expected %h actual %h", $realtime, want[15:0], y);
                errors++;
            end
            if (want[16] !== last) begin
                $display("%0t: last mismatch expected %b actual %b", $realtime, want[16], last);
                errors++;
            end
            matched++;
        endfunction
    endclass

    tanh_scoreboard sb = new();
    bit             no_idle = 1'b0;
    int             stall_left = 0;
    int             nan_seen = 0;

    // Output side: random stall bursts; no new burst starts once no_idle is set.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 12);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check every beat that leaves the pipeline.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_y_bits, o_last_out);
    end

    // Present one beat and hold it until the pipeline takes it.
    task automatic send_beat(input logic [15:0] x, input logic last);
        i_in_valid <= 1'b1;
        i_x_bits   <= x;
        i_last_in  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(x, last);
        if (x[14:10] == 5'h1F && x[9:0] != 10'd0) nan_seen++;
    endtask

    // Drop valid for a random burst, now and then, while idling is allowed.
    task automatic maybe_gap();
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Mostly values inside the clamp window, plus raw patterns and specials.
    function automatic logic [15:0] pick_x();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3) return 16'($urandom);
        if (kind <= 7) return {1'($urandom), 5'($urandom_range(0, 16)), 10'($urandom)};
        if (kind == 8) return {1'($urandom), 15'(16'h4308 + $urandom_range(0, 6) - 3)};
        return {1'($urandom), ($urandom_range(0, 1) ? 5'h1F : 5'h00), 10'($urandom)};
    endfunction

    logic [15:0] directed[$] = '{
        16'h0000, 16'h8000, 16'h3C00, 16'hBC00, 16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01,
        16'hFD55, 16'hFFFF, 16'h0001, 16'h8001, 16'h03FF, 16'h0400, 16'h4308, 16'h4309,
        16'hC308, 16'hC309, 16'h7BFF, 16'hFBFF, 16'h3555, 16'h2000, 16'h1400, 16'hAAAA
    };

    initial begin
        int idx;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, signed zeros, NaNs, infinities and the clamp bounds.
        foreach (directed[k]) begin
            send_beat(directed[k], (k % 5) == 4);
            maybe_gap();
        end

        // Hold off until the pipeline has drained completely.
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);

        for (idx = 0; idx < 1000; idx++) begin
            if (idx == 850) no_idle = 1'b1;
            send_beat(pick_x(), $urandom_range(0, 7) == 0);
            maybe_gap();
        end
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d beats (%0d NaN inputs), directed extremes and random values",
                 sb.matched, nan_seen);
        $display("with input gaps and output stalls, plus a full drain mid-run.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[fp16_tanh_rational_top] OK");
        end else begin
            $display("[fp16_tanh_rational_top] ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("Timed out with %0d beats outstanding", sb.expected_q.size());
        $display("[fp16_tanh_rational_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ftanh_pkg.sv
hw/rtl/fp16_tanh_rational_top.sv
test/tb_top.sv
